[sv/jseu_pkg.sv]
// Shared types, character codes and helpers for the JSON string escaper.
package jseu_pkg;

   localparam int unsigned MAX_RESULTS = 8;
   localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int unsigned UNIT_MAX    = 6;
   localparam int unsigned UNIT_CNT_W  = $clog2(UNIT_MAX + 1);

   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHR_B         = 8'h62;
   localparam logic [7:0] CHR_F         = 8'h66;
   localparam logic [7:0] CHR_N         = 8'h6e;
   localparam logic [7:0] CHR_R         = 8'h72;
   localparam logic [7:0] CHR_T         = 8'h74;
   localparam logic [7:0] CHR_U         = 8'h75;
   localparam logic [7:0] CHR_ZERO      = 8'h30;

   localparam logic [15:0] UNIT_BS  = 16'h0008;
   localparam logic [15:0] UNIT_TAB = 16'h0009;
   localparam logic [15:0] UNIT_LF  = 16'h000a;
   localparam logic [15:0] UNIT_FF  = 16'h000c;
   localparam logic [15:0] UNIT_CR  = 16'h000d;
   localparam logic [15:0] UNIT_QT  = 16'h0022;
   localparam logic [15:0] UNIT_BSL = 16'h005c;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_LONE_HIGH = 2'd1,
      ERR_LONE_LOW  = 2'd2
   } error_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      error_type  err;
   } result_entry_type;

   // Lower-case hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
   endfunction

   function automatic result_entry_type byte_entry(input logic [7:0] b);
      byte_entry.data  = b;
      byte_entry.valid = 1'b1;
      byte_entry.err   = ERR_NONE;
   endfunction

endpackage

[sv/json_string_escape_utf16_to_utf8.sv]
// JSON string escaper: UTF-16 code unit transactions in, quoted UTF-8 byte stream out.
//
// Each input transaction carries one UTF-16 code unit (or none, when no_unit is set) and
// is decoded into up to eight results, which are loaded into a result queue and handed
// out one per cycle while rsp_tready is high. A transaction is taken when the queue is
// empty or its last entry drains, so the block sustains one input per cycle while each
// unit yields a single byte (plain ASCII) and rsp_tready stays high; an item with
// several results holds off the next input until all are out, as the output port is
// one byte wide. Items that yield no result (a pending high surrogate, discarded units)
// leave the queue empty. The opening quote leads the first item of a string, the closing
// quote trails the last. A lone surrogate yields an error result (byte_valid low,
// error_code set) as the final result of its item, after which units are dropped until
// the string ends. rsp_tlast marks the last result of each input transaction.
module json_string_escape_utf16_to_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // code_unit
   input  logic        req_tlast,   // ends_string
   input  logic [1:0]  req_tuser,   // [0] starts_string, [1] no_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic [2:0]  rsp_tuser    // [0] byte_valid, [2:1] error_code
);

   localparam int unsigned NRES = jseu_pkg::MAX_RESULTS;

   // Decoder state
   logic        high_pending_ff, high_pending_in;
   logic [9:0]  high_bits_ff, high_bits_in;
   logic        discarding_ff, discarding_in;

   // Result queue: entry 0 is at the head, shifted down on each output transaction
   jseu_pkg::result_entry_type        queue_ff [NRES];
   jseu_pkg::result_entry_type        queue_in [NRES];
   logic [jseu_pkg::RES_CNT_W-1:0]    count_ff, count_in;

   logic req_fire, rsp_fire;

   // Fields of the incoming transaction
   logic [15:0] unit;
   logic        starts, ends, none;

   assign unit   = req_tdata;
   assign ends   = req_tlast;
   assign starts = req_tuser[0];
   assign none   = req_tuser[1];

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   // Take a new transaction when the queue is empty or drains its last entry now
   assign req_tready = (count_ff == '0) ||
                       ((count_ff == jseu_pkg::RES_CNT_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tdata = queue_ff[0].data;
   assign rsp_tuser = {queue_ff[0].err, queue_ff[0].valid};
   assign rsp_tlast = (count_ff == jseu_pkg::RES_CNT_W'(1));

   // Per-item decode
   jseu_pkg::result_entry_type         unit_bytes [jseu_pkg::UNIT_MAX];
   logic [jseu_pkg::UNIT_CNT_W-1:0]    unit_cnt;
   jseu_pkg::error_type                unit_err, final_err;
   logic                               pend_cur, pend_next;
   logic [9:0]                         bits_next;
   logic                               is_high, is_low;
   logic [20:0]                        cp;
   jseu_pkg::result_entry_type         list [NRES];
   logic [jseu_pkg::RES_CNT_W-1:0]     list_cnt;
   logic                               skip;

   assign is_high = (unit[15:10] == 6'b110110);
   assign is_low  = (unit[15:10] == 6'b110111);
   // Supplementary code point from the pending high half and this low half
   assign cp = 21'h10000 + {1'b0, high_bits_ff, unit[9:0]};

   always_comb begin
      for (int i = 0; i < jseu_pkg::UNIT_MAX; i++) begin
         unit_bytes[i] = jseu_pkg::byte_entry(8'h00);
      end
      unit_cnt  = '0;
      unit_err  = jseu_pkg::ERR_NONE;
      pend_cur  = starts ? 1'b0 : high_pending_ff;
      pend_next = pend_cur;
      bits_next = starts ? 10'd0 : high_bits_ff;

      if (!none) begin
         if (pend_cur) begin
            if (is_low) begin
               unit_bytes[0] = jseu_pkg::byte_entry({5'b11110, cp[20:18]});
               unit_bytes[1] = jseu_pkg::byte_entry({2'b10, cp[17:12]});
               unit_bytes[2] = jseu_pkg::byte_entry({2'b10, cp[11:6]});
               unit_bytes[3] = jseu_pkg::byte_entry({2'b10, cp[5:0]});
               unit_cnt      = jseu_pkg::UNIT_CNT_W'(4);
               pend_next     = 1'b0;
               bits_next     = 10'd0;
            end else begin
               unit_err = jseu_pkg::ERR_LONE_HIGH;
            end
         end else begin
            unit_bytes[0] = jseu_pkg::byte_entry(jseu_pkg::CHR_BACKSLASH);
            unit_cnt      = jseu_pkg::UNIT_CNT_W'(2);
            case (unit)
               jseu_pkg::UNIT_QT:  unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_QUOTE);
               jseu_pkg::UNIT_BSL: unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_BACKSLASH);
               jseu_pkg::UNIT_BS:  unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_B);
               jseu_pkg::UNIT_FF:  unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_F);
               jseu_pkg::UNIT_LF:  unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_N);
               jseu_pkg::UNIT_CR:  unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_R);
               jseu_pkg::UNIT_TAB: unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_T);
               default: begin
                  if (unit < 16'h0020) begin
                     // Other controls: \u00 and two hex digits
                     unit_bytes[1] = jseu_pkg::byte_entry(jseu_pkg::CHR_U);
                     unit_bytes[2] = jseu_pkg::byte_entry(jseu_pkg::CHR_ZERO);
                     unit_bytes[3] = jseu_pkg::byte_entry(jseu_pkg::CHR_ZERO);
                     unit_bytes[4] = jseu_pkg::byte_entry(jseu_pkg::hex_char(unit[7:4]));
                     unit_bytes[5] = jseu_pkg::byte_entry(jseu_pkg::hex_char(unit[3:0]));
                     unit_cnt      = jseu_pkg::UNIT_CNT_W'(6);
                  end else if (is_high) begin
                     unit_cnt  = '0;
                     pend_next = 1'b1;
                     bits_next = unit[9:0];
                  end else if (is_low) begin
                     unit_cnt = '0;
                     unit_err = jseu_pkg::ERR_LONE_LOW;
                  end else if (unit < 16'h0080) begin
                     unit_bytes[0] = jseu_pkg::byte_entry(unit[7:0]);
                     unit_cnt      = jseu_pkg::UNIT_CNT_W'(1);
                  end else if (unit < 16'h0800) begin
                     unit_bytes[0] = jseu_pkg::byte_entry({3'b110, unit[10:6]});
                     unit_bytes[1] = jseu_pkg::byte_entry({2'b10, unit[5:0]});
                     unit_cnt      = jseu_pkg::UNIT_CNT_W'(2);
                  end else begin
                     unit_bytes[0] = jseu_pkg::byte_entry({4'b1110, unit[15:12]});
                     unit_bytes[1] = jseu_pkg::byte_entry({2'b10, unit[11:6]});
                     unit_bytes[2] = jseu_pkg::byte_entry({2'b10, unit[5:0]});
                     unit_cnt      = jseu_pkg::UNIT_CNT_W'(3);
                  end
               end
            endcase
         end
      end

      // A high half still pending at the end of the string is lone
      final_err = unit_err;
      if ((unit_err == jseu_pkg::ERR_NONE) && ends && pend_next) begin
         final_err = jseu_pkg::ERR_LONE_HIGH;
      end
   end

   // Assemble the result list: opening quote, unit bytes, then closing quote or error
   always_comb begin
      logic [jseu_pkg::RES_CNT_W-1:0] pos;
      for (int i = 0; i < NRES; i++) begin
         list[i] = jseu_pkg::byte_entry(8'h00);
      end
      pos = '0;
      if (starts) begin
         list[0] = jseu_pkg::byte_entry(jseu_pkg::CHR_QUOTE);
         pos     = jseu_pkg::RES_CNT_W'(1);
      end
      for (int j = 0; j < jseu_pkg::UNIT_MAX; j++) begin
         if (jseu_pkg::UNIT_CNT_W'(j) < unit_cnt) begin
            list[jseu_pkg::RES_IDX_W'(pos + jseu_pkg::RES_CNT_W'(j))] = unit_bytes[j];
         end
      end
      pos = pos + jseu_pkg::RES_CNT_W'(unit_cnt);
      if (final_err != jseu_pkg::ERR_NONE) begin
         list[pos[jseu_pkg::RES_IDX_W-1:0]].data  = 8'h00;
         list[pos[jseu_pkg::RES_IDX_W-1:0]].valid = 1'b0;
         list[pos[jseu_pkg::RES_IDX_W-1:0]].err   = final_err;
         pos = pos + jseu_pkg::RES_CNT_W'(1);
      end else if (ends) begin
         list[pos[jseu_pkg::RES_IDX_W-1:0]] = jseu_pkg::byte_entry(jseu_pkg::CHR_QUOTE);
         pos = pos + jseu_pkg::RES_CNT_W'(1);
      end
      list_cnt = pos;
   end

   // Drop items of a string that already failed, unless a new string starts
   assign skip = !starts && discarding_ff;

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      discarding_in   = discarding_ff;
      if (req_fire) begin
         if (skip) begin
            if (ends) begin
               discarding_in = 1'b0;
            end
         end else if (final_err != jseu_pkg::ERR_NONE) begin
            high_pending_in = 1'b0;
            high_bits_in    = 10'd0;
            discarding_in   = !ends;
         end else begin
            high_pending_in = pend_next;
            high_bits_in    = bits_next;
            discarding_in   = 1'b0;
         end
      end
   end

   // Queue: load on a new transaction, else shift down on each output transaction
   always_comb begin
      for (int i = 0; i < NRES; i++) begin
         queue_in[i] = queue_ff[i];
      end
      count_in = count_ff;
      if (req_fire) begin
         for (int i = 0; i < NRES; i++) begin
            queue_in[i] = list[i];
         end
         count_in = skip ? '0 : list_cnt;
      end else if (rsp_fire) begin
         for (int i = 0; i < NRES - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         count_in = count_ff - jseu_pkg::RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= 10'd0;
         discarding_ff   <= 1'b0;
         count_ff        <= '0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
         discarding_ff   <= discarding_in;
         count_ff        <= count_in;
      end
   end

   // Payload holds no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < NRES; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

endmodule
